// ----- rtl/flpw_pkg.sv -----
// Shared types and constants for the four-level page walker.
// Used by flpw_ctrl, flpw_dp and four_level_page_walker; no dependencies.
package flpw_pkg;

   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   localparam int PA_W   = 52;
   localparam int VA_W   = 48;
   localparam int PFN_W  = PA_W - 12;
   localparam int IDX_W  = 9;
   localparam int WIDX_W = PFN_W + IDX_W;
   localparam int WADR_W = 12;
   localparam int DATA_W = 64;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_XLATE = 1'b1;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_NP  = 2'd1;
   localparam logic [1:0] ST_OOR = 2'd2;

   localparam logic [1:0] SZ_4K = 2'd0;
   localparam logic [1:0] SZ_2M = 2'd1;
   localparam logic [1:0] SZ_1G = 2'd2;

   // walk level: 3 is the root table, 0 maps 4 KiB pages
   localparam logic [1:0] LVL_ROOT = 2'd3;
   localparam logic [1:0] LVL_1G   = 2'd2;
   localparam logic [1:0] LVL_2M   = 2'd1;
   localparam logic [1:0] LVL_4K   = 2'd0;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_HUGE    = 7;

   typedef struct packed {
      logic       capture;
      logic       mem_wr;
      logic       mem_rd;
      logic       descend;
      logic       finish;
      logic [1:0] fin_status;
      logic [1:0] fin_size;
   } flpw_cmd_type;

   typedef struct packed {
      logic       oor;
      logic       present;
      logic       huge;
      logic [1:0] level;
   } flpw_sts_type;

endpackage

// ----- rtl/four_level_page_walker.sv -----
// Four-level page-table walker over a private 4096 x 64-bit table memory.
// Depends on flpw_pkg, flpw_ctrl and flpw_dp.
//
// A write (req_func 0) leaves the walker idle: busy stays low and the next
// item may start on the following edge; it gives no result. A translate
// holds busy high until its result is shown: each table level passes a
// lookup state, which forms the word index and launches the read of the
// single-port table memory (whose read data is registered), then a read
// state, which checks the returned entry; a done state presents the result.
// A walk that stops early (not present, table outside memory, 1 GiB or
// 2 MiB page) finishes sooner. The result is shown for exactly one cycle
// with rsp_strobe high; the receiver cannot stall it. root_base is written
// through csr_valid/csr_ready, which is ready whenever busy is low. Table
// words read before being written give undefined results.
module four_level_page_walker import flpw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [WADR_W-1:0]   req_word_addr,
   input  logic [DATA_W-1:0]   req_word_data,
   input  logic [VA_W-1:0]     req_virt_addr,
   output logic                rsp_strobe,
   output logic [PA_W-1:0]     rsp_paddr,
   output logic [1:0]          rsp_psize,
   output logic [1:0]          rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [PA_W-1:0]     csr_root_base
);

   flpw_cmd_type cmd;
   flpw_sts_type sts;
   logic         csr_we;

   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   flpw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_func   (req_func),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   flpw_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_we        (csr_we),
      .csr_root_base (csr_root_base),
      .req_word_addr (req_word_addr),
      .req_word_data (req_word_data),
      .req_virt_addr (req_virt_addr),
      .rsp_paddr     (rsp_paddr),
      .rsp_psize     (rsp_psize),
      .rsp_status    (rsp_status)
   );

`ifndef NO_ASSERTIONS
   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("result beat not followed by idle");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_WRITE) |=> !busy && !rsp_strobe)
      else $error("table write disturbed the walker");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> rsp_paddr == '0 && rsp_psize == SZ_4K)
      else $error("faulting result carries address or size");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status <= ST_OOR && rsp_psize <= SZ_1G)
      else $error("unused status or size code on result");
`endif

endmodule

// ----- rtl/flpw_ctrl.sv -----
// Walk controller: sequences table writes and the per-level read/check steps.
// Depends on flpw_pkg; drives flpw_dp through the command struct.
module flpw_ctrl import flpw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_func,
   input  flpw_sts_type sts,
   output flpw_cmd_type cmd,
   output logic         busy,
   output logic         rsp_strobe
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOKUP = 4'b0010,
      S_READ   = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);
   assign accept     = start && !busy;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.fin_status = ST_OK;
      cmd.fin_size   = SZ_4K;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_func == FUNC_WRITE) begin
               cmd.mem_wr = 1'b1;
            end else if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (sts.oor) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ST_OOR;
               state_in       = S_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            if (!sts.present) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ST_NP;
               state_in       = S_DONE;
            end else if (sts.level == LVL_1G && sts.huge) begin
               cmd.finish   = 1'b1;
               cmd.fin_size = SZ_1G;
               state_in     = S_DONE;
            end else if (sts.level == LVL_2M && sts.huge) begin
               cmd.finish   = 1'b1;
               cmd.fin_size = SZ_2M;
               state_in     = S_DONE;
            end else if (sts.level == LVL_4K) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.descend = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/flpw_dp.sv -----
// Walk datapath: table memory, root base register, walk registers and result.
// Depends on flpw_pkg; steered by flpw_ctrl through the command struct.
module flpw_dp import flpw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  flpw_cmd_type        cmd,
   output flpw_sts_type        sts,
   input  logic                csr_we,
   input  logic [PA_W-1:0]     csr_root_base,
   input  logic [WADR_W-1:0]   req_word_addr,
   input  logic [DATA_W-1:0]   req_word_data,
   input  logic [VA_W-1:0]     req_virt_addr,
   output logic [PA_W-1:0]     rsp_paddr,
   output logic [1:0]          rsp_psize,
   output logic [1:0]          rsp_status
);

   logic [DATA_W-1:0] mem_ff [MEM_WORDS];
   logic [DATA_W-1:0] rdata_ff;

   logic [PA_W-1:0]   root_ff;
   logic [VA_W-1:0]   va_ff,    va_in;
   logic [PFN_W-1:0]  tbl_ff,   tbl_in;
   logic [1:0]        level_ff, level_in;
   logic [PA_W-1:0]   pa_ff,    pa_in;
   logic [1:0]        size_ff,  size_in;
   logic [1:0]        stat_ff,  stat_in;

   logic [IDX_W-1:0]  idx;
   logic [WIDX_W-1:0] widx;
   logic              wr_ok;

   always_comb begin
      unique case (level_ff)
         LVL_ROOT: idx = va_ff[47:39];
         LVL_1G:   idx = va_ff[38:30];
         LVL_2M:   idx = va_ff[29:21];
         default:  idx = va_ff[20:12];
      endcase
   end

   assign widx  = {tbl_ff, idx};
   assign wr_ok = (32'(req_word_addr) < MEM_WORDS);

   assign sts.oor     = (widx >= WIDX_W'(MEM_WORDS));
   assign sts.present = rdata_ff[BIT_PRESENT];
   assign sts.huge    = rdata_ff[BIT_HUGE];
   assign sts.level   = level_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && wr_ok) begin
         mem_ff[MEM_AW'(req_word_addr)] <= req_word_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= mem_ff[widx[MEM_AW-1:0]];
      end
   end

   always_comb begin
      va_in    = va_ff;
      tbl_in   = tbl_ff;
      level_in = level_ff;
      if (cmd.capture) begin
         va_in    = req_virt_addr;
         tbl_in   = root_ff[PA_W-1:12];
         level_in = LVL_ROOT;
      end else if (cmd.descend) begin
         tbl_in   = rdata_ff[PA_W-1:12];
         level_in = level_ff - 2'd1;
      end
   end

   // page offset comes from the virtual address, frame bits from the entry
   always_comb begin
      pa_in   = pa_ff;
      size_in = size_ff;
      stat_in = stat_ff;
      if (cmd.finish) begin
         stat_in = cmd.fin_status;
         size_in = cmd.fin_size;
         if (cmd.fin_status != ST_OK) begin
            pa_in = '0;
         end else begin
            case (cmd.fin_size)
               SZ_1G:   pa_in = {rdata_ff[PA_W-1:30], va_ff[29:0]};
               SZ_2M:   pa_in = {rdata_ff[PA_W-1:21], va_ff[20:0]};
               default: pa_in = {rdata_ff[PA_W-1:12], va_ff[11:0]};
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      va_ff    <= va_in;
      tbl_ff   <= tbl_in;
      level_ff <= level_in;
      pa_ff    <= pa_in;
      size_ff  <= size_in;
      stat_ff  <= stat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else if (csr_we) begin
         root_ff <= csr_root_base;
      end
   end

   assign rsp_paddr  = pa_ff;
   assign rsp_psize  = size_ff;
   assign rsp_status = stat_ff;

endmodule
